### rtl/core/rmte_pkg.sv
// shared types and constants for the rotation matrix to euler block
package rmte_pkg;

  localparam int CORDIC_STEPS = 31;
  localparam int SQRT_STEPS   = 32;

  typedef logic signed [44:0] cx_t;
  typedef logic signed [33:0] cz_t;

  localparam cz_t PI_Q28      = 34'sd843314857;
  localparam cz_t HALF_PI_Q28 = 34'sd421657429;

  localparam logic [31:0] ANG_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
  } mat_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    mat_t        m;
  } sq_t;

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  typedef struct packed {
    logic          sing;
    logic [2:0]    zero;
    cx_t  [2:0]    x;
    cx_t  [2:0]    y;
    cz_t  [2:0]    z;
  } cord_t;

endpackage

### rtl/core/rmte_in_if.sv
// input channel: seven matrix elements
interface rmte_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r00;
  logic signed [31:0] r10;
  logic signed [31:0] r11;
  logic signed [31:0] r12;
  logic signed [31:0] r20;
  logic signed [31:0] r21;
  logic signed [31:0] r22;
  modport source (output valid, r00, r10, r11, r12, r20, r21, r22, input ready);
  modport sink (input valid, r00, r10, r11, r12, r20, r21, r22, output ready);
endinterface

### rtl/core/rmte_out_if.sv
// result channel: euler angles and singular flag
interface rmte_out_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] roll_angle;
  logic signed [30:0] pitch_angle;
  logic signed [30:0] yaw_angle;
  logic               is_singular;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, is_singular, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, is_singular, output ready);
endinterface

### rtl/core/rmte_sqrt_cell.sv
// one digit step of the restoring square root
module rmte_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  rmte_pkg::sq_t in_data,
  output logic         out_valid,
  output rmte_pkg::sq_t out_data
);
  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic          valid_r;
  rmte_pkg::sq_t data_r, data_nxt;
  logic [63:0]   trial;

  always_comb begin
    trial    = in_data.root + BIT;
    data_nxt = in_data;
    if (in_data.rem >= trial) begin
      data_nxt.rem  = in_data.rem - trial;
      data_nxt.root = (in_data.root >> 1) + BIT;
    end else begin
      data_nxt.root = in_data.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

### rtl/core/rmte_cordic_cell.sv
// one vectoring step for all three atan2 lanes
module rmte_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  rmte_pkg::cord_t in_data,
  output logic            out_valid,
  output rmte_pkg::cord_t out_data
);
  localparam rmte_pkg::cz_t ANG = rmte_pkg::cz_t'(rmte_pkg::ANG_TAB[SHIFT]);

  logic            valid_r;
  rmte_pkg::cord_t data_r, data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int k = 0; k < 3; k++) begin
      if (in_data.y[k] >= 0) begin
        data_nxt.x[k] = in_data.x[k] + (in_data.y[k] >>> SHIFT);
        data_nxt.y[k] = in_data.y[k] - (in_data.x[k] >>> SHIFT);
        data_nxt.z[k] = in_data.z[k] + ANG;
      end else begin
        data_nxt.x[k] = in_data.x[k] - (in_data.y[k] >>> SHIFT);
        data_nxt.y[k] = in_data.y[k] + (in_data.x[k] >>> SHIFT);
        data_nxt.z[k] = in_data.z[k] - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

### rtl/core/rotation_matrix_to_euler.sv
// top level: zyx euler angles from a rotation matrix
// Takes one matrix item per cycle and returns roll, pitch and yaw (signed
// Q3.28 radians) plus a singular flag, one result per item, in order. The
// steps: a register squares r00 and r10, a register adds them, a row of 32
// square-root cells retires one root bit each, a register picks the atan2
// operands and turns vectors with negative x into the right half plane, a
// row of 31 cordic cells runs the vectoring steps of all three atan2 lanes
// side by side, and an output register rounds, clamps to +-pi and holds the
// result. Sustained rate is one item per cycle; the whole row of cells holds
// only while a result waits at the output and the sink is not ready.
// cfg_wdata is the gimbal-lock threshold in the input's Q format; reset
// value is 1e-6 at FRAC_BITS fraction bits (1074 at 30). Write it only
// while no items are in flight.
module rotation_matrix_to_euler #(
  parameter int FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  rmte_in_if.sink     in_ch,
  rmte_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);
  localparam logic [63:0] THR_FULL = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic [30:0] THR_RESET = THR_FULL[30:0];

  localparam int SQ = rmte_pkg::SQRT_STEPS;
  localparam int CS = rmte_pkg::CORDIC_STEPS;

  // threshold register
  logic [30:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // whole row advances unless a result is stuck at the output
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage: squares
  logic          sq_valid_r;
  logic [63:0]   a2_r, b2_r;
  rmte_pkg::mat_t mat_r;
  logic [31:0]   abs_a, abs_b;

  assign abs_a = in_ch.r00[31] ? 32'(-in_ch.r00) : in_ch.r00;
  assign abs_b = in_ch.r10[31] ? 32'(-in_ch.r10) : in_ch.r10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (en) begin
      sq_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= {32'd0, abs_a} * {32'd0, abs_a};
      b2_r  <= {32'd0, abs_b} * {32'd0, abs_b};
      mat_r <= '{in_ch.r00, in_ch.r10, in_ch.r11, in_ch.r12, in_ch.r20, in_ch.r21, in_ch.r22};
    end
  end

  // stage: sum of squares enters the root row
  logic          sum_valid_r;
  rmte_pkg::sq_t sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (en) begin
      sum_valid_r <= sq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r.rem  <= a2_r + b2_r;
      sum_r.root <= '0;
      sum_r.m    <= mat_r;
    end
  end

  // square-root row
  logic          sv [SQ+1];
  rmte_pkg::sq_t sd [SQ+1];
  assign sv[0] = sum_valid_r;
  assign sd[0] = sum_r;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    rmte_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sv[g]), .in_data(sd[g]),
      .out_valid(sv[g+1]), .out_data(sd[g+1])
    );
  end

  // operand select and half-plane turn
  function automatic rmte_pkg::cord_t set_lane(input rmte_pkg::cord_t c, input int k,
                                               input logic signed [32:0] yin,
                                               input logic signed [32:0] xin);
    rmte_pkg::cord_t r;
    rmte_pkg::cx_t   xs, ys;
    rmte_pkg::cz_t   a0;
    r  = c;
    xs = rmte_pkg::cx_t'(xin) <<< 8;
    ys = rmte_pkg::cx_t'(yin) <<< 8;
    a0 = rmte_pkg::cz_t'(rmte_pkg::ANG_TAB[0]) <<< 1;
    r.zero[k] = (xs == 0) && (ys == 0);
    if (xs < 0) begin
      if (ys >= 0) begin
        r.x[k] = ys;
        r.y[k] = -xs;
        r.z[k] = a0;
      end else begin
        r.x[k] = -ys;
        r.y[k] = xs;
        r.z[k] = -a0;
      end
    end else begin
      r.x[k] = xs;
      r.y[k] = ys;
      r.z[k] = '0;
    end
    return r;
  endfunction

  logic                sy_sing;
  logic signed [32:0]  sy_s;
  rmte_pkg::mat_t      mq;
  rmte_pkg::cord_t     pre_nxt, pre_r;
  logic                pre_valid_r;

  assign mq      = sd[SQ].m;
  assign sy_s    = {1'b0, sd[SQ].root[31:0]};
  assign sy_sing = sd[SQ].root < {33'd0, thr_r};

  always_comb begin
    pre_nxt      = '0;
    pre_nxt.sing = sy_sing;
    if (sy_sing) begin
      pre_nxt = set_lane(pre_nxt, 0, -33'(mq.r12), 33'(mq.r11));
    end else begin
      pre_nxt = set_lane(pre_nxt, 0, 33'(mq.r21), 33'(mq.r22));
    end
    pre_nxt = set_lane(pre_nxt, 1, -33'(mq.r20), sy_s);
    pre_nxt = set_lane(pre_nxt, 2, 33'(mq.r10), 33'(mq.r00));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (en) begin
      pre_valid_r <= sv[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  // cordic row
  logic            cv [CS+1];
  rmte_pkg::cord_t cd [CS+1];
  assign cv[0] = pre_valid_r;
  assign cd[0] = pre_r;

  for (genvar g = 0; g < CS; g++) begin : g_cordic
    rmte_cordic_cell #(.SHIFT(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(cv[g]), .in_data(cd[g]),
      .out_valid(cv[g+1]), .out_data(cd[g+1])
    );
  end

  // round to q3.28 and clamp to +-pi
  function automatic logic signed [30:0] to_angle(input rmte_pkg::cz_t z, input logic zero);
    rmte_pkg::cz_t r;
    r = (z + 34'sd2) >>> 2;
    if (r > rmte_pkg::PI_Q28) r = rmte_pkg::PI_Q28;
    if (r < -rmte_pkg::PI_Q28) r = -rmte_pkg::PI_Q28;
    if (zero) r = '0;
    return r[30:0];
  endfunction

  rmte_pkg::cord_t    cl;
  logic signed [30:0] roll_r, pitch_r, yaw_r;
  logic               sing_r;
  assign cl = cd[CS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= to_angle(cl.z[0], cl.zero[0]);
      pitch_r <= to_angle(cl.z[1], cl.zero[1]);
      yaw_r   <= to_angle(cl.z[2], cl.zero[2] || cl.sing);
      sing_r  <= cl.sing;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle   = yaw_r;
  assign out_ch.is_singular = sing_r;

  // yaw is forced to zero on the gimbal-lock branch
  a_yaw_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_singular |-> out_ch.yaw_angle == 31'sd0)
    else $error("yaw not zero on singular item");

  // pitch x operand is a magnitude, so pitch stays within +-pi/2 plus cordic error
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (34'(out_ch.pitch_angle) <= rmte_pkg::HALF_PI_Q28 + 34'sd16) &&
                     (34'(out_ch.pitch_angle) >= -rmte_pkg::HALF_PI_Q28 - 34'sd16))
    else $error("pitch outside half pi");

  // roll after clamp within +-pi
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (34'(out_ch.roll_angle) <= rmte_pkg::PI_Q28) &&
                     (34'(out_ch.roll_angle) >= -rmte_pkg::PI_Q28))
    else $error("roll outside pi");

  // a held result keeps the whole row frozen
  a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(cv[CS]) && $stable(pre_valid_r))
    else $error("row moved while output stalled");
endmodule
